>>> rtl/ttw_pkg.sv
`default_nettype none

package ttw_pkg;

    localparam int COLS_DEF = 80;
    localparam int ROWS_DEF = 25;

    localparam logic [7:0] ATTR_RESET = 8'h07;
    localparam logic [7:0] CH_NULL    = 8'h00;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_SPACE   = 8'h20;

    localparam logic REQ_PUT  = 1'b0;
    localparam logic REQ_READ = 1'b1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RWAIT,
        S_COPY,
        S_BLANK,
        S_EMIT
    } t_state;

endpackage

`default_nettype wire

>>> rtl/ttw_screen_ram.sv
`default_nettype none

module ttw_screen_ram
    import ttw_pkg::*;
#(
    parameter int DEPTH = COLS_DEF * ROWS_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [15:0]   i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [15:0]   o_rdata
);

    logic [15:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> rtl/text_mode_terminal_writer_top.sv
`default_nettype none

// Channel      Direction  Handshake                   Content
// s_axis       in         i_s_axis_tvalid/o_..tready  put or read request
// m_axis       out        o_m_axis_tvalid/i_..tready  cursor and cell read
// cfg          in         i_cfg_valid/o_cfg_ready     text attribute byte
//
// After reset a clearing pass fills the screen; no request is taken.
// A read goes through the registered read port of the screen memory.
// A put that scrolls copies one cell per cycle, then the bottom row is blanked.
// One request at a time; the next is taken while the last result waits in the output register.
// Reset is synchronous, active low; cfg is always ready.

module text_mode_terminal_writer_top
    import ttw_pkg::*;
#(
    parameter int COLS = COLS_DEF,
    parameter int ROWS = ROWS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [23:0] i_s_axis_tdata,   // char_code, read_col, read_row
    input  wire logic        i_s_axis_tuser,   // req_type
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic      [31:0] o_m_axis_tdata,   // cursor_col, cursor_row, cell_value
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [7:0]  i_cfg_data        // text_attribute
);

    localparam int N  = COLS * ROWS;
    localparam int AW = (N > 1) ? $clog2(N) : 1;
    localparam int CW = $clog2(N + 1);
    localparam logic [CW-1:0] COLS_C    = CW'(COLS);
    localparam logic [CW-1:0] LAST_COPY = CW'(N - COLS);
    localparam logic [CW-1:0] LAST_CELL = CW'(N - 1);

    t_state          r_state, n_state;
    logic [CW-1:0]   r_idx, n_idx;
    logic [6:0]      r_col, n_col;
    logic [4:0]      r_row, n_row;
    logic [15:0]     r_cell, n_cell;
    logic [7:0]      r_attr;
    logic            r_out_valid;
    logic [31:0]     r_out_data;

    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [15:0]     ram_wdata;
    logic [AW-1:0]   ram_raddr;
    logic [15:0]     ram_rdata;

    logic            s_acc;
    logic            in_req;
    logic [7:0]      in_char;
    logic [6:0]      in_col;
    logic [4:0]      in_row;
    logic [CW-1:0]   cur_addr;
    logic [CW-1:0]   rd_addr;
    logic [CW-1:0]   copy_src;
    logic [CW-1:0]   copy_dst;
    logic [7:0]      col_inc;
    logic [5:0]      row_inc;
    logic            adv_row;
    logic            emit_go;

    assign in_char = i_s_axis_tdata[7:0];
    assign in_col  = i_s_axis_tdata[14:8];
    assign in_row  = i_s_axis_tdata[19:15];
    assign in_req  = i_s_axis_tuser;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign s_acc           = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cfg_ready     = 1'b1;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign emit_go         = (r_state == S_EMIT) && (!r_out_valid || i_m_axis_tready);

    assign cur_addr = CW'(r_row) * COLS_C + CW'(r_col);
    assign rd_addr  = CW'(in_row) * COLS_C + CW'(in_col);
    assign copy_src = r_idx + COLS_C;
    assign copy_dst = r_idx - CW'(1);
    assign col_inc  = {1'b0, r_col} + 8'd1;
    assign row_inc  = {1'b0, r_row} + 6'd1;

    ttw_screen_ram #(
        .DEPTH (N),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_col     = r_col;
        n_row     = r_row;
        n_cell    = r_cell;
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = {r_attr, CH_SPACE};
        ram_raddr = '0;
        adv_row   = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_idx[AW-1:0];
                ram_wdata = {ATTR_RESET, CH_SPACE};
                if (r_idx == LAST_CELL) begin
                    n_idx   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_idx = r_idx + CW'(1);
                end
            end
            S_IDLE: begin
                if (s_acc) begin
                    n_cell  = '0;
                    n_state = S_EMIT;
                    if (in_req == REQ_READ) begin
                        if (({1'b0, in_col} < 8'(COLS)) && ({1'b0, in_row} < 6'(ROWS))) begin
                            ram_raddr = rd_addr[AW-1:0];
                            n_state   = S_RWAIT;
                        end
                    end else begin
                        priority if (in_char == CH_NEWLINE) begin
                            adv_row = 1'b1;
                        end else if (in_char != CH_NULL) begin
                            ram_we    = 1'b1;
                            ram_waddr = cur_addr[AW-1:0];
                            ram_wdata = {r_attr, in_char};
                            if (col_inc == 8'(COLS)) begin
                                adv_row = 1'b1;
                            end else begin
                                n_col = col_inc[6:0];
                            end
                        end
                    end
                    if (adv_row) begin
                        n_col = '0;
                        if (row_inc == 6'(ROWS)) begin
                            n_idx   = '0;
                            n_state = S_COPY;
                        end else begin
                            n_row = row_inc[4:0];
                        end
                    end
                end
            end
            S_RWAIT: begin
                n_cell  = ram_rdata;
                n_state = S_EMIT;
            end
            S_COPY: begin
                if (r_idx != LAST_COPY) begin
                    ram_raddr = copy_src[AW-1:0];
                end
                if (r_idx != '0) begin
                    ram_we    = 1'b1;
                    ram_waddr = copy_dst[AW-1:0];
                    ram_wdata = ram_rdata;
                end
                if (r_idx == LAST_COPY) begin
                    n_state = S_BLANK;
                end else begin
                    n_idx = r_idx + CW'(1);
                end
            end
            S_BLANK: begin
                ram_we    = 1'b1;
                ram_waddr = r_idx[AW-1:0];
                if (r_idx == LAST_CELL) begin
                    n_idx   = '0;
                    n_state = S_EMIT;
                end else begin
                    n_idx = r_idx + CW'(1);
                end
            end
            S_EMIT: begin
                if (emit_go) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_idx   <= '0;
            r_col   <= '0;
            r_row   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_col   <= n_col;
            r_row   <= n_row;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cell <= n_cell;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr <= ATTR_RESET;
        end else if (i_cfg_valid) begin
            r_attr <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit_go) begin
            r_out_valid <= 1'b1;
            r_out_data  <= {4'b0000, r_cell, r_row, r_col};
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc |=> !o_s_axis_tready)
        else $error("request taken while previous one in progress");

    a_cursor_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_col} < 8'(COLS)) && ({1'b0, r_row} < 6'(ROWS)))
        else $error("cursor outside screen");

    a_null_keeps_cursor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc && (in_req == REQ_PUT) && (in_char == CH_NULL)
            |=> $stable(r_col) && $stable(r_row) && (r_state == S_EMIT))
        else $error("null character moved cursor");

    a_scroll_on_last_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COPY) |-> (r_col == '0) && (row_inc == 6'(ROWS)))
        else $error("scroll with cursor off the bottom row");

    a_blank_then_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BLANK) && (r_idx == LAST_CELL) |=> (r_state == S_EMIT))
        else $error("scroll did not finish");

endmodule

`default_nettype wire
